@@ rtl/core/pll_angle_speed_observer_core_macros.svh @@
// Assertion macros for the PLL angle/speed observer core checker.
// Self-contained; no dependencies.
`ifndef PLL_ANGLE_SPEED_OBSERVER_CORE_MACROS_SVH
`define PLL_ANGLE_SPEED_OBSERVER_CORE_MACROS_SVH

// same-cycle implication
`define PASO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("paso assertion failed");

// next-cycle implication
`define PASO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("paso assertion failed");

`endif

@@ rtl/core/paso_pkg.sv @@
// Shared types and constants for the PLL angle/speed observer core.
// No dependencies.
package paso_pkg;

  localparam int ANG_W       = 16;
  localparam int KP_W        = 24;
  localparam int KI_W        = 24;
  localparam int LIM_W       = 18;
  localparam int STEP_W      = 16;
  localparam int SPEED_W     = 19;
  localparam int RPM_W       = 15;
  localparam int INTEG_W     = 35;
  localparam int GAIN_SHIFT  = 16;
  localparam int RPM_SHIFT   = 16;
  localparam logic [11:0] RPM_FACTOR = 12'd2445;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // register indexes on the cfg channel
  localparam logic [CFG_IDX_W-1:0] REG_KP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 8'd3;

  typedef struct packed {
    logic [KP_W-1:0]   kp;
    logic [KI_W-1:0]   ki;
    logic [LIM_W-1:0]  limit;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic err;
    logic mul;
    logic integ;
    logic spd;
    logic mul2;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/pll_angle_speed_observer_core.sv @@
// PLL angle/speed observer. Each input item carries a measured rotor angle
// (signed 16 bit, 32768 = pi) on s_tdata and a restart flag on s_tuser; each
// produces one output item with speed in rad/s Q.8, speed in rpm and the
// tracked angle. After the accepting cycle the sequencer steps the error,
// gain multiply, integrator clamp, speed clamp, scaling multiply and
// accumulator update one per cycle; s_tready returns as the output register
// is loaded, so no new item is taken before then. A held output stalls the
// last step. The user must make configuration writes on the cfg channel only
// while the block is idle; the block itself does not enforce this.
// Depends on paso_pkg, paso_cfg, paso_ctrl, paso_dp.
module pll_angle_speed_observer_core #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [paso_pkg::ANG_W-1:0]       s_tdata,   // [15:0] angle_in
  input  logic                             s_tuser,   // [0] restart
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [18:0] speed_rad, [33:19] speed_rpm, [49:34] angle_out, [55:50] zero
  output logic [paso_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [paso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [paso_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import paso_pkg::*;

  cfg_t  regs;
  cmd_t  cmd;
  stat_t stat;

  paso_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  paso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  paso_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .cmd      (cmd),
    .stat     (stat),
    .angle_in (s_tdata),
    .restart  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ rtl/core/paso_cfg.sv @@
// Configuration register file: gains, speed limit, step gain.
// Depends on paso_pkg.
module paso_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [paso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [paso_pkg::CFG_DATA_W-1:0] cfg_data,
  output paso_pkg::cfg_t                  regs
);
  import paso_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp    <= KP_W'(321699);
      regs.ki    <= KI_W'(316228);
      regs.limit <= LIM_W'(160850);
      regs.step  <= STEP_W'(1602);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KP:    regs.kp    <= cfg_data[KP_W-1:0];
        REG_KI:    regs.ki    <= cfg_data[KI_W-1:0];
        REG_LIMIT: regs.limit <= cfg_data[LIM_W-1:0];
        REG_STEP:  regs.step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/paso_ctrl.sv @@
// Sequencing state machine for the observer datapath.
// Depends on paso_pkg.
module paso_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  paso_pkg::stat_t stat,
  output paso_pkg::cmd_t  cmd
);
  import paso_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ERR  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_INT  = 7'b0001000,
    ST_SPD  = 7'b0010000,
    ST_MUL2 = 7'b0100000,
    ST_UPD  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == ST_IDLE);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.err   = (state == ST_ERR);
  assign cmd.mul   = (state == ST_MUL);
  assign cmd.integ = (state == ST_INT);
  assign cmd.spd   = (state == ST_SPD);
  assign cmd.mul2  = (state == ST_MUL2);
  assign cmd.upd   = (state == ST_UPD) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_INT;
      ST_INT:  state_next = ST_SPD;
      ST_SPD:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_UPD;
      ST_UPD:  if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/paso_dp.sv @@
// Observer datapath: angle error, PI loop with clamps, rpm scaling,
// angle accumulator and output register. Depends on paso_pkg.
module paso_dp #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  paso_pkg::cfg_t                   cfg,
  input  paso_pkg::cmd_t                   cmd,
  output paso_pkg::stat_t                  stat,
  input  logic [paso_pkg::ANG_W-1:0]       angle_in,
  input  logic                             restart,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [paso_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import paso_pkg::*;

  localparam int AB  = ANGLE_BITS;
  localparam int AW  = ANGLE_BITS + GAIN_SHIFT;
  localparam int WB  = (ANGLE_BITS > ANG_W) ? ANGLE_BITS : ANG_W;
  localparam int PW  = ANGLE_BITS + KP_W + 1 - GAIN_SHIFT;
  localparam int SSW = PW + 1;

  logic [ANG_W-1:0]          ang_q;
  logic                      rst_q;
  logic signed [AB-1:0]      err_q;
  logic signed [PW-1:0]      p_q;
  logic signed [PW-1:0]      i_q;
  logic signed [INTEG_W-1:0] integ;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [RPM_W-1:0]   rpm_q;
  logic [AW-1:0]             step_q;
  logic [AW-1:0]             acc;

  logic [WB-1:0]               in_w;
  logic [AB-1:0]               meas;
  logic [AB-1:0]               tracked;
  logic [AB-1:0]               err_d;
  logic signed [AB+KP_W:0]     kp_prod;
  logic signed [AB+KI_W:0]     ki_prod;
  logic signed [INTEG_W:0]     isum;
  logic signed [INTEG_W:0]     ilim;
  logic signed [INTEG_W:0]     iclamp;
  logic signed [SSW-1:0]       ssum;
  logic signed [SSW-1:0]       slim;
  logic signed [SSW-1:0]       sclamp;
  logic signed [SPEED_W+12:0]  rpm_prod;
  logic signed [AW+SPEED_W:0]  step_prod;
  logic [AW-1:0]               acc_new;
  logic [AB-1:0]               tnew;
  logic [WB-1:0]               ao_w;
  logic [ANG_W-1:0]            angle_o;

  // error against tracked angle, wraps at AB bits
  always_comb begin
    in_w    = WB'(ang_q) << (WB - ANG_W);
    meas    = in_w[WB-1 -: AB];
    tracked = acc[AW-1:GAIN_SHIFT];
    err_d   = meas - tracked;
  end

  assign kp_prod = err_q * $signed({1'b0, cfg.kp});
  assign ki_prod = err_q * $signed({1'b0, cfg.ki});

  always_comb begin
    isum = (INTEG_W+1)'(integ) + (INTEG_W+1)'(i_q);
    ilim = $signed((INTEG_W+1)'({cfg.limit, {GAIN_SHIFT{1'b0}}}));
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  always_comb begin
    ssum = SSW'(p_q) + SSW'($signed(integ_new[INTEG_W-1:GAIN_SHIFT]));
    slim = $signed(SSW'(cfg.limit));
    if (ssum > slim) begin
      sclamp = slim;
    end else if (ssum < -slim) begin
      sclamp = -slim;
    end else begin
      sclamp = ssum;
    end
  end

  assign rpm_prod  = speed_q * $signed({1'b0, RPM_FACTOR});
  assign step_prod = speed_q * $signed({1'b0, cfg.step});

  always_comb begin
    acc_new = acc + step_q;
    tnew    = acc_new[AW-1:GAIN_SHIFT];
    ao_w    = WB'(tnew) << (WB - AB);
    angle_o = ao_w[WB-1 -: ANG_W];
  end

  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_q <= angle_in;
      rst_q <= restart;
    end
    if (cmd.err) begin
      err_q <= err_d;
    end
    if (cmd.mul) begin
      p_q <= kp_prod[AB+KP_W:GAIN_SHIFT];
      i_q <= ki_prod[AB+KI_W:GAIN_SHIFT];
    end
    if (cmd.integ) begin
      integ_new <= INTEG_W'(iclamp);
    end
    if (cmd.spd) begin
      speed_q <= SPEED_W'(sclamp);
    end
    if (cmd.mul2) begin
      rpm_q  <= rpm_prod[RPM_SHIFT+RPM_W-1:RPM_SHIFT];
      step_q <= step_prod[AW-1:0];
    end
    if (cmd.upd) begin
      if (rst_q) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= OUT_TDATA_W'({angle_o, rpm_q, speed_q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        m_tvalid <= 1'b1;
        if (rst_q) begin
          integ <= '0;
          acc   <= '0;
        end else begin
          integ <= integ_new;
          acc   <= acc_new;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/paso_chk.sv @@
// Port-level checker for the PLL angle/speed observer core, with its bind.
// Depends on paso_pkg and the assertion macro header.
`include "pll_angle_speed_observer_core_macros.svh"

module paso_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [paso_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import paso_pkg::*;

  // output item holds until taken
  `PASO_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // output data holds while the item waits
  `PASO_ASSERT_NXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // one item in flight at a time
  `PASO_ASSERT_NXT(a_one_inflight, clk, rst, s_tvalid && s_tready, !s_tready)
  // a fresh output follows an accepted item after the full sequence of steps
  `PASO_ASSERT_IMP(a_latency, clk, rst, $rose(m_tvalid), $past(s_tvalid && s_tready, 7))

endmodule

bind pll_angle_speed_observer_core paso_chk u_paso_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/pll_angle_speed_observer_core_tb.sv @@
// Self-checking testbench for pll_angle_speed_observer_core: drives angle items and
// register writes, predicts each result in-line and checks m_tdata field by field.
// Depends on paso_pkg and the core RTL only.
`timescale 1ns / 1ps

module pll_angle_speed_observer_core_tb;
  import paso_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 10;

  typedef struct {
    logic [ANG_W-1:0] angle;
    logic             restart;
    bit               drain;
  } angle_item_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic [ANG_W-1:0]   angle_out;
    logic [RPM_W-1:0]   speed_rpm;
    logic [SPEED_W-1:0] speed_rad;
  } speed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ANG_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pll_angle_speed_observer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  angle_item_t   pending_items[$];
  speed_result_t expected_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  // observer state and register shadow
  logic [KP_W-1:0]   kp_gain = 24'd321699;
  logic [KI_W-1:0]   ki_gain = 24'd316228;
  logic [LIM_W-1:0]  speed_limit = 18'd160850;
  logic [STEP_W-1:0] step_gain = 16'd1602;
  longint            integ_acc = 0;
  logic [31:0]       phase_acc = '0;

  function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_KP:    kp_gain = val[KP_W-1:0];
      REG_KI:    ki_gain = val[KI_W-1:0];
      REG_LIMIT: speed_limit = val[LIM_W-1:0];
      REG_STEP:  step_gain = val[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic speed_result_t track_angle_step(input logic [ANG_W-1:0] angle,
                                                     input logic restart);
    speed_result_t r;
    logic [ANG_W-1:0] err_w;
    longint err, kp, ki, lim, stp, p_term, spd, rpm, inc;
    r = '0;
    if (restart) begin
      integ_acc = 0;
      phase_acc = '0;
      return r;
    end
    kp = kp_gain;
    ki = ki_gain;
    lim = speed_limit;
    stp = step_gain;
    err_w = angle - phase_acc[31:16];
    err = $signed(err_w);
    p_term = (err * kp) >>> GAIN_SHIFT;
    integ_acc = integ_acc + ((err * ki) >>> GAIN_SHIFT);
    if (integ_acc > (lim <<< GAIN_SHIFT)) integ_acc = lim <<< GAIN_SHIFT;
    if (integ_acc < -(lim <<< GAIN_SHIFT)) integ_acc = -(lim <<< GAIN_SHIFT);
    spd = p_term + (integ_acc >>> GAIN_SHIFT);
    if (spd > lim) spd = lim;
    if (spd < -lim) spd = -lim;
    rpm = (spd * 2445) >>> RPM_SHIFT;
    inc = spd * stp;
    phase_acc = phase_acc + inc[31:0];
    r.speed_rad = spd[SPEED_W-1:0];
    r.speed_rpm = rpm[RPM_W-1:0];
    r.angle_out = phase_acc[31:16];
    return r;
  endfunction

  task automatic flag_field(input string name, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", name, want, got);
  endtask

  // sender
  always @(posedge clk) begin
    bit take;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(track_angle_step(s_tdata, s_tuser));
      if (!s_tvalid || s_tready) begin
        take = pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct;
        if (take && pending_items[0].drain && expected_results.size() > 0) take = 0;
        if (take) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_items[0].angle;
          s_tuser <= pending_items[0].restart;
          void'(pending_items.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    speed_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          flag_field("unexpected item", 0, $signed(got.speed_rad));
        end else begin
          want = expected_results.pop_front();
          if (got.speed_rad !== want.speed_rad)
            flag_field("speed_rad", $signed(want.speed_rad), $signed(got.speed_rad));
          if (got.speed_rpm !== want.speed_rpm)
            flag_field("speed_rpm", $signed(want.speed_rpm), $signed(got.speed_rpm));
          if (got.angle_out !== want.angle_out)
            flag_field("angle_out", $signed(want.angle_out), $signed(got.angle_out));
          if (got.pad !== 6'd0)
            flag_field("pad", 0, got.pad);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    shadow_reg_write(idx, val);
  endtask

  task automatic queue_item(input int angle, input bit restart, input bit drain);
    angle_item_t it;
    it.angle = angle[ANG_W-1:0];
    it.restart = restart;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  initial begin
    int track, rate, pick;
    logic [CFG_DATA_W-1:0] kp_v, ki_v, lim_v, step_v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    queue_item(12345, 1, 0);
    queue_item(0, 0, 0);
    queue_item(32767, 0, 0);
    queue_item(-32768, 0, 0);
    queue_item(32767, 0, 0);
    queue_item(-32768, 0, 0);
    queue_item(1, 0, 0);
    queue_item(-1, 0, 0);
    queue_item(16384, 0, 0);
    queue_item(-16384, 0, 0);
    queue_item(16'h5555, 0, 0);
    queue_item(16'hAAAA, 0, 1);
    queue_item(-32768, 1, 0);
    queue_item(-32768, 0, 0);
    queue_item(32767, 0, 0);
    queue_item(0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          kp_v = 24'hFFFFFF; ki_v = 24'hFFFFFF; lim_v = 24'hFFFFFF; step_v = 24'hFFFFFF;
        end
        1: begin
          kp_v = 24'd0; ki_v = 24'hFFFFFF; lim_v = 24'hFC0000; step_v = 24'hFF0000;
        end
        2: begin
          kp_v = 24'd321699; ki_v = 24'd316228; lim_v = 24'd160850; step_v = 24'd1602;
        end
        default: begin
          kp_v = 24'($urandom) >> $urandom_range(0, 10);
          ki_v = 24'($urandom) >> $urandom_range(2, 14);
          lim_v = 24'($urandom) >> $urandom_range(0, 6);
          step_v = 24'($urandom) >> $urandom_range(0, 8);
        end
      endcase
      write_reg(REG_KP, kp_v);
      write_reg(REG_KI, ki_v);
      write_reg(REG_LIMIT, lim_v);
      write_reg(REG_STEP, step_v);
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), 24'($urandom));

      case (ph / 3)
        0: begin send_idle_pct = 33; recv_stall_pct = 74; end
        1: begin send_idle_pct = 74; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase

      track = $urandom_range(0, 65535);
      rate = $urandom_range(0, 4000) - 2000;
      for (int i = 0; i < 125; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          queue_item($urandom, 1, i == 60);
        end else if (pick < 30) begin
          queue_item($urandom, 0, i == 60);
        end else begin
          track = track + rate + $urandom_range(0, 64) - 32;
          queue_item(track, 0, i == 60);
        end
      end
      wait_idle();
    end

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
